@@ rtl/imq_pkg.sv @@
package imq_pkg;

    localparam int KEY_W      = 8;
    localparam int OPC_W      = 2;
    localparam int STAT_W     = 3;
    localparam int OUT_PRIO_W = 32;
    localparam int CNT_OUT_W  = 9;

    localparam logic [OPC_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OPC_W-1:0] OP_ERASE = 2'd1;
    localparam logic [OPC_W-1:0] OP_POP   = 2'd2;
    localparam logic [OPC_W-1:0] OP_QUERY = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_ABSENT = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUP    = 3'd4;

    typedef struct packed {
        logic [OUT_PRIO_W-1:0] key_priority;
        logic                  key_present;
        logic [CNT_OUT_W-1:0]  entry_count;
        logic [OUT_PRIO_W-1:0] top_priority;
        logic [KEY_W-1:0]      top_key;
        logic                  top_valid;
        logic [STAT_W-1:0]     status;
    } imq_result_t;

endpackage

@@ rtl/imq_ram.sv @@
module imq_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/imq_core.sv @@
module imq_core #(
    parameter int KEY_COUNT      = 256,
    parameter int PRIORITY_WIDTH = 32,
    parameter int POS_W          = 9,
    parameter int KIDX_W         = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [imq_pkg::OPC_W-1:0]             in_opcode,
    input  logic [imq_pkg::KEY_W-1:0]             in_key,
    input  logic [imq_pkg::OUT_PRIO_W-1:0]        in_prio,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output imq_pkg::imq_result_t                  res,
    output logic                                  heap_we,
    output logic [POS_W-1:0]                      heap_wa,
    output logic [imq_pkg::KEY_W+PRIORITY_WIDTH-1:0] heap_wd,
    output logic [POS_W-1:0]                      heap_ra,
    input  logic [imq_pkg::KEY_W+PRIORITY_WIDTH-1:0] heap_rd,
    output logic                                  pos_we,
    output logic [KIDX_W-1:0]                     pos_wa,
    output logic [POS_W-1:0]                      pos_wd,
    output logic [KIDX_W-1:0]                     pos_ra,
    input  logic [POS_W-1:0]                      pos_rd
);

    localparam int KW    = imq_pkg::KEY_W;
    localparam int PW    = PRIORITY_WIDTH;
    localparam int ENT_W = KW + PW;
    localparam logic [POS_W-1:0]  FULL_CNT = POS_W'(KEY_COUNT);
    localparam logic [POS_W-1:0]  ROOT     = POS_W'(1);
    localparam logic [KIDX_W-1:0] LAST_KEY = KIDX_W'(KEY_COUNT - 1);

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_LOOK  = 15'b000000000000100,
        S_POP   = 15'b000000000001000,
        S_LAST  = 15'b000000000010000,
        S_UP    = 15'b000000000100000,
        S_UPCMP = 15'b000000001000000,
        S_DOWN  = 15'b000000010000000,
        S_DNL   = 15'b000000100000000,
        S_DNR   = 15'b000001000000000,
        S_DNCMP = 15'b000010000000000,
        S_F1    = 15'b000100000000000,
        S_F2    = 15'b001000000000000,
        S_F3    = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [imq_pkg::OPC_W-1:0]     op_reg, op_next;
    logic [KW-1:0]                 key_reg, key_next;
    logic [PW-1:0]                 prio_reg, prio_next;
    logic                          inr_reg, inr_next;
    logic [POS_W-1:0]              cnt_reg, cnt_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [ENT_W-1:0]              mv_reg, mv_next;
    logic [ENT_W-1:0]              ch_reg, ch_next;
    logic [POS_W-1:0]              cidx_reg, cidx_next;
    logic                          rm_reg, rm_next;
    logic                          moved_reg, moved_next;
    logic [imq_pkg::STAT_W-1:0]    status_reg, status_next;
    logic [KIDX_W-1:0]             clr_reg, clr_next;
    logic [ENT_W-1:0]              top_reg, top_next;
    logic                          kpres_reg, kpres_next;
    logic [PW-1:0]                 kpr_reg, kpr_next;

    logic [POS_W:0]                lc;
    logic [POS_W:0]                rc;
    logic [POS_W-1:0]              p;
    logic [PW-1:0]                 rd_prio;
    logic [PW-1:0]                 mv_prio;
    logic [PW-1:0]                 ch_prio;
    logic [KIDX_W-1:0]             key_idx;

    assign lc      = {pos_reg, 1'b0};
    assign rc      = lc + (POS_W+1)'(1);
    assign p       = inr_reg ? pos_rd : '0;
    assign rd_prio = heap_rd[ENT_W-1:KW];
    assign mv_prio = mv_reg[ENT_W-1:KW];
    assign ch_prio = ch_reg[ENT_W-1:KW];
    assign key_idx = KIDX_W'(key_reg);

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        prio_next   = prio_reg;
        inr_next    = inr_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        mv_next     = mv_reg;
        ch_next     = ch_reg;
        cidx_next   = cidx_reg;
        rm_next     = rm_reg;
        moved_next  = moved_reg;
        status_next = status_reg;
        clr_next    = clr_reg;
        top_next    = top_reg;
        kpres_next  = kpres_reg;
        kpr_next    = kpr_reg;
        heap_we     = 1'b0;
        heap_wa     = pos_reg;
        heap_wd     = mv_reg;
        heap_ra     = ROOT;
        pos_we      = 1'b0;
        pos_wa      = KIDX_W'(mv_reg[KW-1:0]);
        pos_wd      = pos_reg;
        pos_ra      = key_idx;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                pos_we   = 1'b1;
                pos_wa   = clr_reg;
                pos_wd   = '0;
                clr_next = clr_reg + KIDX_W'(1);
                if (clr_reg == LAST_KEY) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                pos_ra   = KIDX_W'(in_key);
                if (in_valid) begin
                    op_next     = in_opcode;
                    key_next    = in_key;
                    prio_next   = PW'(in_prio);
                    inr_next    = 32'(in_key) < 32'(KEY_COUNT);
                    status_next = imq_pkg::ST_OK;
                    rm_next     = 1'b0;
                    moved_next  = 1'b0;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK: begin
                state_next = S_F1;
                case (op_reg)
                    imq_pkg::OP_PUSH: begin
                        if (!inr_reg) begin
                            status_next = imq_pkg::ST_ABSENT;
                        end else if (p != '0) begin
                            status_next = imq_pkg::ST_DUP;
                        end else if (cnt_reg >= FULL_CNT) begin
                            status_next = imq_pkg::ST_FULL;
                        end else begin
                            cnt_next   = cnt_reg + POS_W'(1);
                            pos_next   = cnt_reg + POS_W'(1);
                            mv_next    = {prio_reg, key_reg};
                            state_next = S_UP;
                        end
                    end
                    imq_pkg::OP_ERASE: begin
                        if (p == '0) begin
                            status_next = imq_pkg::ST_ABSENT;
                        end else begin
                            pos_we   = 1'b1;
                            pos_wa   = key_idx;
                            pos_wd   = '0;
                            cnt_next = cnt_reg - POS_W'(1);
                            if (p != cnt_reg) begin
                                heap_ra    = cnt_reg;
                                pos_next   = p;
                                rm_next    = 1'b1;
                                state_next = S_LAST;
                            end
                        end
                    end
                    imq_pkg::OP_POP: begin
                        if (cnt_reg == '0) begin
                            status_next = imq_pkg::ST_EMPTY;
                        end else begin
                            heap_ra    = ROOT;
                            state_next = S_POP;
                        end
                    end
                    default: begin
                        state_next = S_F1;
                    end
                endcase
            end
            S_POP: begin
                pos_we     = 1'b1;
                pos_wa     = KIDX_W'(heap_rd[KW-1:0]);
                pos_wd     = '0;
                cnt_next   = cnt_reg - POS_W'(1);
                state_next = S_F1;
                if (cnt_reg != ROOT) begin
                    heap_ra    = cnt_reg;
                    pos_next   = ROOT;
                    rm_next    = 1'b1;
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                mv_next    = heap_rd;
                state_next = S_UP;
            end
            S_UP: begin
                if (pos_reg == ROOT) begin
                    if (rm_reg && !moved_reg) begin
                        state_next = S_DOWN;
                    end else begin
                        heap_we    = 1'b1;
                        pos_we     = 1'b1;
                        state_next = S_F1;
                    end
                end else begin
                    heap_ra    = pos_reg >> 1;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (mv_prio < rd_prio) begin
                    heap_we    = 1'b1;
                    heap_wd    = heap_rd;
                    pos_we     = 1'b1;
                    pos_wa     = KIDX_W'(heap_rd[KW-1:0]);
                    pos_next   = pos_reg >> 1;
                    moved_next = 1'b1;
                    state_next = S_UP;
                end else if (rm_reg && !moved_reg) begin
                    state_next = S_DOWN;
                end else begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_F1;
                end
            end
            S_DOWN: begin
                if (lc > {1'b0, cnt_reg}) begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_F1;
                end else begin
                    heap_ra    = POS_W'(lc);
                    state_next = S_DNL;
                end
            end
            S_DNL: begin
                ch_next   = heap_rd;
                cidx_next = POS_W'(lc);
                if (rc <= {1'b0, cnt_reg}) begin
                    heap_ra    = POS_W'(rc);
                    state_next = S_DNR;
                end else begin
                    state_next = S_DNCMP;
                end
            end
            S_DNR: begin
                if (rd_prio < ch_prio) begin
                    ch_next   = heap_rd;
                    cidx_next = POS_W'(rc);
                end
                state_next = S_DNCMP;
            end
            S_DNCMP: begin
                if (ch_prio < mv_prio) begin
                    heap_we    = 1'b1;
                    heap_wd    = ch_reg;
                    pos_we     = 1'b1;
                    pos_wa     = KIDX_W'(ch_reg[KW-1:0]);
                    pos_next   = cidx_reg;
                    state_next = S_DOWN;
                end else begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_F1;
                end
            end
            S_F1: begin
                heap_ra    = ROOT;
                state_next = S_F2;
            end
            S_F2: begin
                top_next   = heap_rd;
                kpres_next = p != '0;
                heap_ra    = p;
                state_next = S_F3;
            end
            S_F3: begin
                kpr_next   = rd_prio;
                state_next = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        res.status       = status_reg;
        res.top_valid    = cnt_reg != '0;
        res.top_key      = (cnt_reg != '0) ? top_reg[KW-1:0] : '0;
        res.top_priority = (cnt_reg != '0) ? imq_pkg::OUT_PRIO_W'(top_reg[ENT_W-1:KW]) : '0;
        res.entry_count  = imq_pkg::CNT_OUT_W'(cnt_reg);
        res.key_present  = kpres_reg;
        res.key_priority = kpres_reg ? imq_pkg::OUT_PRIO_W'(kpr_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
        op_reg     <= op_next;
        key_reg    <= key_next;
        prio_reg   <= prio_next;
        inr_reg    <= inr_next;
        pos_reg    <= pos_next;
        mv_reg     <= mv_next;
        ch_reg     <= ch_next;
        cidx_reg   <= cidx_next;
        rm_reg     <= rm_next;
        moved_reg  <= moved_next;
        status_reg <= status_next;
        top_reg    <= top_next;
        kpres_reg  <= kpres_next;
        kpr_reg    <= kpr_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL_CNT)
        else $error("entry count exceeds capacity");

    a_heap_pos_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        heap_we |-> pos_we)
        else $error("heap slot written without position update");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_we |-> pos_wd <= cnt_reg)
        else $error("position written beyond occupied slots");

    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while waiting for output");
`endif

endmodule

@@ rtl/indexed_min_priority_queue.sv @@
// Indexed binary min-heap of (key, priority) entries. Each input transfer carries one
// operation (push, erase by key, pop, or query) and produces exactly one result transfer
// with a status, the top entry, the entry count and the lookup of the input key. After
// reset the key position table is cleared one entry at a time, during which s_tready
// stays low. An operation then walks the heap level by level as it climbs or descends;
// the single read port of the heap memory is visited once per level climbed and once per
// child on the way down. A finished result waits in the output register while the next
// transfer is processed.
module indexed_min_priority_queue #(
    parameter int KEY_COUNT      = 256,
    parameter int PRIORITY_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_key[7:0], item_priority[39:8]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // status, top_valid, top_key, top_priority,
                                   // entry_count, key_present, key_priority, zero pad
);

    localparam int POS_W  = $clog2(KEY_COUNT + 1);
    localparam int KIDX_W = $clog2(KEY_COUNT);
    localparam int ENT_W  = imq_pkg::KEY_W + PRIORITY_WIDTH;

    logic                 res_valid;
    logic                 res_ready;
    imq_pkg::imq_result_t res;
    logic                 heap_we;
    logic [POS_W-1:0]     heap_wa;
    logic [ENT_W-1:0]     heap_wd;
    logic [POS_W-1:0]     heap_ra;
    logic [ENT_W-1:0]     heap_rd;
    logic                 pos_we;
    logic [KIDX_W-1:0]    pos_wa;
    logic [POS_W-1:0]     pos_wd;
    logic [KIDX_W-1:0]    pos_ra;
    logic [POS_W-1:0]     pos_rd;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [87:0]          m_tdata_reg, m_tdata_next;

    imq_ram #(
        .DEPTH (KEY_COUNT + 1),
        .ADDR_W(POS_W),
        .DATA_W(ENT_W)
    ) u_heap_ram (
        .aclk   (aclk),
        .wr_en  (heap_we),
        .wr_addr(heap_wa),
        .wr_data(heap_wd),
        .rd_addr(heap_ra),
        .rd_data(heap_rd)
    );

    imq_ram #(
        .DEPTH (KEY_COUNT),
        .ADDR_W(KIDX_W),
        .DATA_W(POS_W)
    ) u_pos_ram (
        .aclk   (aclk),
        .wr_en  (pos_we),
        .wr_addr(pos_wa),
        .wr_data(pos_wd),
        .rd_addr(pos_ra),
        .rd_data(pos_rd)
    );

    imq_core #(
        .KEY_COUNT     (KEY_COUNT),
        .PRIORITY_WIDTH(PRIORITY_WIDTH),
        .POS_W         (POS_W),
        .KIDX_W        (KIDX_W)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_opcode(s_tuser),
        .in_key   (s_tdata[7:0]),
        .in_prio  (s_tdata[39:8]),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .heap_we  (heap_we),
        .heap_wa  (heap_wa),
        .heap_wd  (heap_wd),
        .heap_ra  (heap_ra),
        .heap_rd  (heap_rd),
        .pos_we   (pos_we),
        .pos_wa   (pos_wa),
        .pos_wd   (pos_wd),
        .pos_ra   (pos_ra),
        .pos_rd   (pos_rd)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_tdata_next = {2'b00, res};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
